### rtl/rdc_pkg.sv
// shared types, constants and helpers for the radix digit converter
// no dependencies

package rdc_pkg;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;
    localparam int POS_W   = 5;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd97;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // status from the divider to the sequencer
    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] rem;
    } div_stat_t;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DEC_LIMIT)
            return CHAR_ZERO + ext;
        else
            return CHAR_ALPHA + ext - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_LIMIT};
    endfunction

endpackage

### rtl/radix_digit_converter_unit.sv
// radix digit converter top level: sequencer, radix register, output register
// depends on rdc_pkg and rdc_divider
//
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  input    | in_valid, in_stall, value                       | in
//  output   | out_valid, out_stall, digit, digit_char,        | out
//           | position, last, empty_res, bad_base             |
//  config   | radix_we, radix_wdata                           | in
//
// each digit runs through the shared bit-serial divider and then waits in the pending
// register until it is handed to the output register; a bad radix or a zero input
// skips the divider and goes straight from idle to the emit state
// reset clears the sequencer, the output valid and sets radix to 10
// in_stall is high from acceptance until the last result of the item is loaded
// a stalled output holds the sequencer in the emit state

module radix_digit_converter_unit #(
    parameter int VALUE_BITS = 31
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [VALUE_BITS-1:0]             value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rdc_pkg::DIGIT_W-1:0]       digit,
    output logic [rdc_pkg::CHAR_W-1:0]        digit_char,
    output logic [rdc_pkg::POS_W-1:0]         position,
    output logic                              last,
    output logic                              empty_res,
    output logic                              bad_base,
    input  logic                              radix_we,
    input  logic [rdc_pkg::RADIX_W-1:0]       radix_wdata
);
    import rdc_pkg::*;

    state_t state_reg, state_next;

    logic [RADIX_W-1:0]    radix_reg;
    logic [VALUE_BITS-1:0] quot_reg;
    logic [POS_W-1:0]      pos_reg;

    // pending result waiting for the output register
    logic [DIGIT_W-1:0]    pend_digit_reg;
    logic [CHAR_W-1:0]     pend_char_reg;
    logic [POS_W-1:0]      pend_pos_reg;
    logic                  pend_last_reg;
    logic                  pend_empty_reg;
    logic                  pend_bad_reg;

    logic                  out_valid_reg;
    logic [DIGIT_W-1:0]    out_digit_reg;
    logic [CHAR_W-1:0]     out_char_reg;
    logic [POS_W-1:0]      out_pos_reg;
    logic                  out_last_reg;
    logic                  out_empty_reg;
    logic                  out_bad_reg;

    logic                  accept;
    logic                  radix_ok;
    logic                  value_zero;
    logic                  out_free;
    logic                  load_out;
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_quot;
    div_stat_t             div_stat;

    assign radix_ok   = (radix_reg inside {[RADIX_MIN:RADIX_MAX]});
    assign value_zero = (value == '0);
    assign out_free   = !out_valid_reg || !out_stall;

    // fsm outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        accept    = in_valid && (state_reg == ST_IDLE);
        load_out  = (state_reg == ST_EMIT) && out_free;
        div_start = (accept && radix_ok && !value_zero)
                 || (load_out && !pend_last_reg);
    end

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = (radix_ok && !value_zero) ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = pend_last_reg ? ST_IDLE : ST_DIV;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign div_dividend = (state_reg == ST_IDLE) ? value : quot_reg;

    rdc_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (radix_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radix_reg     <= RADIX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (radix_we)
                radix_reg <= radix_wdata;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg        <= '0;
            pend_digit_reg <= '0;
            pend_pos_reg   <= '0;
            pend_last_reg  <= 1'b1;
            pend_empty_reg <= radix_ok;
            pend_bad_reg   <= !radix_ok;
            pend_char_reg  <= radix_ok ? CHAR_ZERO : '0;
        end
        else if ((state_reg == ST_DIV) && div_stat.done)
        begin
            quot_reg       <= div_quot;
            pend_digit_reg <= div_stat.rem;
            pend_char_reg  <= digit_to_char(div_stat.rem);
            pend_pos_reg   <= pos_reg;
            pend_last_reg  <= (div_quot == '0);
            pend_empty_reg <= 1'b0;
            pend_bad_reg   <= 1'b0;
            pos_reg        <= pos_reg + 1'b1;
        end
        if (load_out)
        begin
            out_digit_reg <= pend_digit_reg;
            out_char_reg  <= pend_char_reg;
            out_pos_reg   <= pend_pos_reg;
            out_last_reg  <= pend_last_reg;
            out_empty_reg <= pend_empty_reg;
            out_bad_reg   <= pend_bad_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit      = out_digit_reg;
    assign digit_char = out_char_reg;
    assign position   = out_pos_reg;
    assign last       = out_last_reg;
    assign empty_res  = out_empty_reg;
    assign bad_base   = out_bad_reg;

endmodule

### rtl/rdc_divider.sv
// bit-serial restoring divider: one quotient bit per cycle
// depends on rdc_pkg

module rdc_divider #(
    parameter int VALUE_BITS = 31
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [VALUE_BITS-1:0]            dividend,
    input  logic [rdc_pkg::RADIX_W-1:0]      divisor,
    output logic [VALUE_BITS-1:0]            quotient,
    output rdc_pkg::div_stat_t               stat
);
    import rdc_pkg::*;

    localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [DIGIT_W-1:0]    r_reg, r_next;
    logic [RADIX_W-1:0]    d_reg, d_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [RADIX_W-1:0]    trial;
    logic [RADIX_W-1:0]    diff;
    logic                  ge;

    // partial remainder stays below divisor, so shifted value fits five bits
    assign trial = {r_reg, q_reg[VALUE_BITS-1]};
    assign ge    = (trial >= d_reg);
    assign diff  = trial - d_reg;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = CNT_W'(VALUE_BITS - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            q_next   = {q_reg[VALUE_BITS-2:0], ge};
            r_next   = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quotient  = q_reg;
    assign stat.done = done_reg;
    assign stat.rem  = r_reg;

endmodule

### rtl/rdc_checker.sv
// port-level checks for the radix digit converter, bound to the top level
// depends on rdc_pkg and radix_digit_converter_unit

module rdc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [rdc_pkg::DIGIT_W-1:0]  digit,
    input logic [rdc_pkg::CHAR_W-1:0]   digit_char,
    input logic [rdc_pkg::POS_W-1:0]    position,
    input logic                         last,
    input logic                         empty_res,
    input logic                         bad_base
);
    import rdc_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(digit) && $stable(digit_char)
            && $stable(position) && $stable(last) && $stable(empty_res)
            && $stable(bad_base))
        else $error("stalled result changed");

    a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_base |-> last && !empty_res && digit == '0
            && digit_char == '0 && position == '0)
        else $error("bad radix result malformed");

    a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last && !bad_base && digit == '0
            && digit_char == CHAR_ZERO && position == '0)
        else $error("empty result malformed");

    a_char_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_base |-> digit_char == digit_to_char(digit))
        else $error("digit character mismatch");

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit      (digit),
    .digit_char (digit_char),
    .position   (position),
    .last       (last),
    .empty_res  (empty_res),
    .bad_base   (bad_base)
);
